[src/dtq_pkg.sv]
// shared constants, types and helpers of the deadline timer queue
package dtq_pkg;

    localparam int SLOTS       = 16;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int MAX_EXPIRED = 16;
    localparam int EXP_W       = $clog2(MAX_EXPIRED + 1);

    localparam int SEC_W   = 32;
    localparam int USEC_W  = 20;
    localparam int ID_W    = 15;
    localparam int TAG_W   = 32;
    localparam int DELAY_W = 31;
    localparam int IDLE_W  = 16;
    localparam int Q_W     = 12;

    localparam logic [USEC_W-1:0]  TICK_US    = USEC_W'(1000000);
    localparam logic [ID_W-1:0]    ID_WRAP    = ID_W'(32760);
    localparam logic [IDLE_W-1:0]  IDLE_RESET = IDLE_W'(1000);
    // ceil(2^50 / 1e6), exact quotient for any 31-bit dividend
    localparam logic [DELAY_W-1:0] RECIP      = DELAY_W'(1125899907);
    localparam int                 RECIP_SH   = 50;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_REMOVE  = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_WAIT    = 2'd3;

    typedef struct packed {
        logic       in_ready;
        logic       load_in;
        logic       step_div;
        logic       step_rem;
        logic       step_sum;
        logic       emit;
        logic [1:0] kind;
        logic       last;
        logic       do_insert;
        logic       do_remove;
        logic       do_pop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_op;
        logic       out_free;
        logic       head_due;
    } dp_status_t;

    // true if time a is strictly later than time b
    function automatic logic later(input logic [SEC_W-1:0] as, input logic [USEC_W-1:0] au,
                                   input logic [SEC_W-1:0] bs, input logic [USEC_W-1:0] bu);
        logic r;
        if (as != bs)
        begin
            r = as > bs;
        end
        else
        begin
            r = au > bu;
        end
        return r;
    endfunction

endpackage

[src/dtq_in_if.sv]
// request channel into the timer queue
interface dtq_in_if;
    import dtq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic [DELAY_W-1:0]   delay_us;
    logic [TAG_W-1:0]     user_tag;
    logic [ID_W-1:0]      timer_id;
    logic [SEC_W-1:0]     now_sec;
    logic [USEC_W-1:0]    now_usec;

    modport source (output valid, operation, delay_us, user_tag, timer_id, now_sec, now_usec,
                    input ready);
    modport sink (input valid, operation, delay_us, user_tag, timer_id, now_sec, now_usec,
                  output ready);
endinterface

[src/dtq_out_if.sv]
// result channel out of the timer queue
interface dtq_out_if;
    import dtq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [ID_W-1:0]      result_id;
    logic [TAG_W-1:0]     result_tag;
    logic                 found;
    logic [SEC_W-1:0]     wait_sec;
    logic [USEC_W-1:0]    wait_usec;
    logic                 last;

    modport source (output valid, kind, result_id, result_tag, found, wait_sec, wait_usec, last,
                    input ready);
    modport sink (input valid, kind, result_id, result_tag, found, wait_sec, wait_usec, last,
                  output ready);
endinterface

[src/dtq_ctrl.sv]
// sequencing state machine of the timer queue
module dtq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  dtq_pkg::dp_status_t stat,
    output dtq_pkg::ctrl_cmd_t  cmd
);
    import dtq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_REM  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_INS  = 3'd4;
    localparam logic [2:0] ST_REMV = 3'd5;
    localparam logic [2:0] ST_CHK  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [EXP_W-1:0] n_reg, n_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        n_next     = n_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.load_in = 1'b1;
                    n_next      = '0;
                    case (stat.in_op)
                        OP_ADD:    state_next = ST_DIV;
                        OP_REMOVE: state_next = ST_REMV;
                        OP_CHECK:  state_next = ST_CHK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.step_div = 1'b1;
                state_next   = ST_REM;
            end
            ST_REM:
            begin
                cmd.step_rem = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.step_sum = 1'b1;
                state_next   = ST_INS;
            end
            ST_INS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = KIND_ADD;
                    cmd.last      = 1'b1;
                    cmd.do_insert = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_REMV:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = KIND_REMOVE;
                    cmd.last      = 1'b1;
                    cmd.do_remove = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CHK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.head_due && (n_reg < EXP_W'(MAX_EXPIRED)))
                    begin
                        cmd.kind   = KIND_EXPIRED;
                        cmd.do_pop = 1'b1;
                        n_next     = n_reg + 1'b1;
                    end
                    else
                    begin
                        cmd.kind   = KIND_WAIT;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

endmodule

[src/dtq_datapath.sv]
// timer slots, deadline arithmetic and result register
module dtq_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dtq_pkg::ctrl_cmd_t    cmd,
    output dtq_pkg::dp_status_t   stat,
    dtq_in_if.sink                in_ch,
    dtq_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [dtq_pkg::IDLE_W-1:0] cfg_wdata
);
    import dtq_pkg::*;

    // request registers
    logic [DELAY_W-1:0] delay_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [ID_W-1:0]    rid_reg;
    logic [SEC_W-1:0]   ns_reg;
    logic [USEC_W-1:0]  nu_reg;
    // add arithmetic
    logic [Q_W-1:0]     q_reg;
    logic [USEC_W-1:0]  r_reg;
    logic [SEC_W-1:0]   ds_reg;
    logic [USEC_W-1:0]  du_reg;
    // slots
    logic [SEC_W-1:0]   sec_reg  [SLOTS];
    logic [USEC_W-1:0]  usec_reg [SLOTS];
    logic [ID_W-1:0]    id_reg   [SLOTS];
    logic [TAG_W-1:0]   stag_reg [SLOTS];
    logic [CNT_W-1:0]   count_reg;
    logic [ID_W-1:0]    idc_reg;
    logic [IDLE_W-1:0]  idle_reg;
    // result
    logic               ovalid_reg;
    logic [1:0]         okind_reg;
    logic [ID_W-1:0]    oid_reg;
    logic [TAG_W-1:0]   otag_reg;
    logic               ofound_reg;
    logic [SEC_W-1:0]   ows_reg;
    logic [USEC_W-1:0]  owu_reg;
    logic               olast_reg;

    // input time normalization
    logic               now_carry;
    logic [SEC_W-1:0]   ns_in;
    logic [USEC_W-1:0]  nu_in;
    always_comb
    begin
        now_carry = in_ch.now_usec >= TICK_US;
        nu_in     = now_carry ? in_ch.now_usec - TICK_US : in_ch.now_usec;
        ns_in     = (now_carry && (in_ch.now_sec != '1)) ? in_ch.now_sec + 1'b1
                                                         : in_ch.now_sec;
    end

    // quotient by reciprocal multiply
    logic [2*DELAY_W-1:0] prod;
    logic [SEC_W-1:0]     qm;
    logic [USEC_W:0]      du_sum;
    logic                 du_carry;
    logic [SEC_W+1:0]     ds_sum;
    always_comb
    begin
        prod     = delay_reg * RECIP;
        qm       = SEC_W'(q_reg) * SEC_W'(TICK_US);
        du_sum   = {1'b0, r_reg} + {1'b0, nu_reg};
        du_carry = du_sum >= {1'b0, TICK_US};
        ds_sum   = {2'b0, ns_reg} + (SEC_W+2)'(q_reg) + (SEC_W+2)'(du_carry);
    end

    // slot compares
    logic [SLOTS-1:0] valid_v, gt_v, hit_v, after_hit;
    logic             full, hit_any;
    logic [ID_W-1:0]  new_id;
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            valid_v[i] = CNT_W'(i) < count_reg;
            gt_v[i]    = valid_v[i] && later(sec_reg[i], usec_reg[i], ds_reg, du_reg);
            hit_v[i]   = valid_v[i] && (rid_reg != '0) && (id_reg[i] == rid_reg);
        end
        after_hit[0] = hit_v[0];
        for (int i = 1; i < SLOTS; i++)
        begin
            after_hit[i] = after_hit[i-1] | hit_v[i];
        end
        hit_any = |hit_v;
        full    = count_reg >= CNT_W'(SLOTS);
        new_id  = idc_reg + 1'b1;
    end

    logic head_due;
    logic [SEC_W-1:0]  wait_s;
    logic [USEC_W-1:0] wait_u;
    always_comb
    begin
        head_due = (count_reg != '0) && !later(sec_reg[0], usec_reg[0], ns_reg, nu_reg);
        wait_s   = '0;
        wait_u   = '0;
        if (count_reg == '0)
        begin
            wait_s = SEC_W'(idle_reg);
        end
        else if (!head_due)
        begin
            if (usec_reg[0] >= nu_reg)
            begin
                wait_u = usec_reg[0] - nu_reg;
                wait_s = sec_reg[0] - ns_reg;
            end
            else
            begin
                wait_u = usec_reg[0] + TICK_US - nu_reg;
                wait_s = sec_reg[0] - ns_reg - 1'b1;
            end
        end
    end

    assign stat.in_valid = in_ch.valid;
    assign stat.in_op    = in_ch.operation;
    assign stat.out_free = !ovalid_reg || out_ch.ready;
    assign stat.head_due = head_due;
    assign in_ch.ready   = cmd.in_ready;

    assign out_ch.valid      = ovalid_reg;
    assign out_ch.kind       = okind_reg;
    assign out_ch.result_id  = oid_reg;
    assign out_ch.result_tag = otag_reg;
    assign out_ch.found      = ofound_reg;
    assign out_ch.wait_sec   = ows_reg;
    assign out_ch.wait_usec  = owu_reg;
    assign out_ch.last       = olast_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            delay_reg <= in_ch.delay_us;
            tag_reg   <= in_ch.user_tag;
            rid_reg   <= in_ch.timer_id;
            ns_reg    <= ns_in;
            nu_reg    <= nu_in;
        end
        if (cmd.step_div)
        begin
            q_reg <= prod[RECIP_SH +: Q_W];
        end
        if (cmd.step_rem)
        begin
            r_reg <= USEC_W'(SEC_W'(delay_reg) - qm);
        end
        if (cmd.step_sum)
        begin
            du_reg <= du_carry ? USEC_W'(du_sum - {1'b0, TICK_US}) : du_sum[USEC_W-1:0];
            ds_reg <= (ds_sum[SEC_W+1:SEC_W] != 2'b00) ? '1 : ds_sum[SEC_W-1:0];
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (cmd.do_insert && !full)
            begin
                if ((i > 0) && gt_v[(i > 0) ? i-1 : 0])
                begin
                    sec_reg[i]  <= sec_reg[(i > 0) ? i-1 : 0];
                    usec_reg[i] <= usec_reg[(i > 0) ? i-1 : 0];
                    id_reg[i]   <= id_reg[(i > 0) ? i-1 : 0];
                    stag_reg[i] <= stag_reg[(i > 0) ? i-1 : 0];
                end
                else if (gt_v[i] || (CNT_W'(i) == count_reg))
                begin
                    sec_reg[i]  <= ds_reg;
                    usec_reg[i] <= du_reg;
                    id_reg[i]   <= new_id;
                    stag_reg[i] <= tag_reg;
                end
            end
            else if ((cmd.do_remove && after_hit[i]) || cmd.do_pop)
            begin
                if (i < SLOTS - 1)
                begin
                    sec_reg[i]  <= sec_reg[(i < SLOTS - 1) ? i+1 : i];
                    usec_reg[i] <= usec_reg[(i < SLOTS - 1) ? i+1 : i];
                    id_reg[i]   <= id_reg[(i < SLOTS - 1) ? i+1 : i];
                    stag_reg[i] <= stag_reg[(i < SLOTS - 1) ? i+1 : i];
                end
            end
        end
        if (cmd.emit)
        begin
            okind_reg  <= cmd.kind;
            olast_reg  <= cmd.last;
            oid_reg    <= '0;
            otag_reg   <= '0;
            ofound_reg <= 1'b0;
            ows_reg    <= '0;
            owu_reg    <= '0;
            case (cmd.kind)
                KIND_ADD:     oid_reg <= full ? '0 : new_id;
                KIND_REMOVE:  ofound_reg <= hit_any;
                KIND_EXPIRED:
                begin
                    oid_reg  <= id_reg[0];
                    otag_reg <= stag_reg[0];
                end
                KIND_WAIT:
                begin
                    ows_reg <= wait_s;
                    owu_reg <= wait_u;
                end
                default:
                begin
                    oid_reg <= '0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idc_reg    <= '0;
            idle_reg   <= IDLE_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                idle_reg <= cfg_wdata;
            end
            if (cmd.do_insert && !full)
            begin
                count_reg <= count_reg + 1'b1;
                idc_reg   <= (new_id == ID_WRAP) ? '0 : new_id;
            end
            else if ((cmd.do_remove && hit_any) || cmd.do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

endmodule

[src/deadline_timer_queue_unit.sv]
// top level of the deadline timer queue
// sequence: add steps through divide, remainder, sum and insert states before its result;
// remove and check emit from their own state; check then gives one result per cycle while
// the sink is ready, one expired result per due timer before its wait result; one request
// at a time, and the next request is taken while the last result still waits
// reset: asynchronous, clears the queue, id counter, output valid; idle wait back to 1000
module deadline_timer_queue_unit (
    input  logic             clk,
    input  logic             rst_n,
    dtq_in_if.sink           in_ch,
    dtq_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [dtq_pkg::IDLE_W-1:0] cfg_wdata
);
    import dtq_pkg::*;

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // sequencer: walks add through its arithmetic steps, loops a check over due timers
    dtq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: sorted slot array kept as a shift register, one output register
    dtq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule
